// ===== rtl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Action codes shared by the fixed-point ALU and its testbench.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int unsigned ActionBits = 4;

   typedef enum logic [ActionBits-1:0] {
      ACT_ADD      = 4'd0,
      ACT_SUB      = 4'd1,
      ACT_MUL      = 4'd2,
      ACT_DIV      = 4'd3,
      ACT_GT       = 4'd4,
      ACT_LT       = 4'd5,
      ACT_GE       = 4'd6,
      ACT_LE       = 4'd7,
      ACT_EQ       = 4'd8,
      ACT_NE       = 4'd9,
      ACT_MAX      = 4'd10,
      ACT_MIN      = 4'd11,
      ACT_INC      = 4'd12,
      ACT_FROM_INT = 4'd13,
      ACT_TO_INT   = 4'd14,
      ACT_NONE     = 4'd15
   } action_type;

endpackage

// ===== rtl/fpa_div.sv =====
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fpa_div #(
   parameter int unsigned WORD_BITS = 32,
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                             clock,
   input  logic                             advance,
   input  logic [WORD_BITS-1:0]             dividend,
   input  logic [WORD_BITS-1:0]             divisor,
   output logic [WORD_BITS+FRAC_BITS-1:0]   quotient
);

   localparam int unsigned N = WORD_BITS + FRAC_BITS;

   logic [WORD_BITS-1:0] rem_ff [N];
   logic [N-1:0]         num_ff [N];
   logic [N-1:0]         quo_ff [N];
   logic [WORD_BITS-1:0] den_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [WORD_BITS-1:0] rem_prev;
      logic [N-1:0]         num_prev;
      logic [N-1:0]         quo_prev;
      logic [WORD_BITS-1:0] den_prev;
      logic [WORD_BITS:0]   trial;
      logic                 fits;
      logic [WORD_BITS-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = {dividend, {FRAC_BITS{1'b0}}};
         assign quo_prev = '0;
         assign den_prev = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      // shift in the next dividend bit, subtract when the divisor fits
      assign trial  = {rem_prev, num_prev[N-1]};
      assign fits   = trial >= {1'b0, den_prev};
      assign rem_in = fits ? WORD_BITS'(trial - {1'b0, den_prev}) : trial[WORD_BITS-1:0];

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= {num_prev[N-2:0], 1'b0};
            quo_ff[k] <= {quo_prev[N-2:0], fits};
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quotient = quo_ff[N-1];

endmodule

// ===== rtl/fixed_point_alu_q24_8.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed Q24.8 fixed-point ALU: arithmetic, compare, min/max and conversions.
// ----------------------------------------------------------------------------
// One word enters per cycle and one result word leaves per cycle while the
// output is not stalled. The pipeline depth is set by the divider, which
// retires one quotient bit per stage. All other operations ride a delay
// line beside the divider so results leave in order. The whole pipe holds
// while a result waits under rsp_stall; req_stall then rises to hold the
// incoming word. Divide by zero returns 0; flag is set only by comparisons.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
   parameter int unsigned FRAC_BITS = 8,
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [3:0]                  req_action,
   input  logic signed [WORD_BITS-1:0] req_operand_a,
   input  logic signed [WORD_BITS-1:0] req_operand_b,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_result,
   output logic                        rsp_flag
);

   localparam int unsigned N = WORD_BITS + FRAC_BITS;

   // side data that travels beside the divider
   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic                 negate;
      logic                 zero_div;
      logic [WORD_BITS-1:0] result;
      logic                 flag;
   } side_type;

   logic advance;

   // input stage
   logic                        in_valid_ff;
   fpa_pkg::action_type         in_action_ff;
   logic signed [WORD_BITS-1:0] in_a_ff;
   logic signed [WORD_BITS-1:0] in_b_ff;

   side_type side_ff [N];
   side_type side_in;

   logic [WORD_BITS-1:0]         mag_a;
   logic [WORD_BITS-1:0]         mag_b;
   logic signed [2*WORD_BITS-1:0] product;
   logic                         a_gt_b;
   logic                         b_gt_a;
   logic [N-1:0]                 quotient;

   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] rsp_result_ff;
   logic                 rsp_flag_ff;
   logic [WORD_BITS-1:0] quo_word;
   logic [WORD_BITS-1:0] final_result;

   // advance the whole pipe unless a finished word is held at the output
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_action_ff <= fpa_pkg::action_type'(req_action);
         in_a_ff      <= req_operand_a;
         in_b_ff      <= req_operand_b;
      end
   end

   // magnitudes for the divider; the most negative value maps to 2^(W-1)
   assign mag_a   = in_a_ff[WORD_BITS-1] ? WORD_BITS'(-in_a_ff) : in_a_ff;
   assign mag_b   = in_b_ff[WORD_BITS-1] ? WORD_BITS'(-in_b_ff) : in_b_ff;
   assign product = in_a_ff * in_b_ff;
   assign a_gt_b  = in_a_ff > in_b_ff;
   assign b_gt_a  = in_b_ff > in_a_ff;

   // resolve every operation but divide in the first side stage
   always_comb begin
      side_in          = '0;
      side_in.valid    = in_valid_ff;
      side_in.is_div   = (in_action_ff == fpa_pkg::ACT_DIV);
      side_in.negate   = in_a_ff[WORD_BITS-1] ^ in_b_ff[WORD_BITS-1];
      side_in.zero_div = (in_b_ff == '0);
      case (in_action_ff)
         fpa_pkg::ACT_ADD:      side_in.result = WORD_BITS'(in_a_ff + in_b_ff);
         fpa_pkg::ACT_SUB:      side_in.result = WORD_BITS'(in_a_ff - in_b_ff);
         fpa_pkg::ACT_MUL:      side_in.result = product[FRAC_BITS +: WORD_BITS];
         fpa_pkg::ACT_GT:       side_in.flag   = a_gt_b;
         fpa_pkg::ACT_LT:       side_in.flag   = b_gt_a;
         fpa_pkg::ACT_GE:       side_in.flag   = !b_gt_a;
         fpa_pkg::ACT_LE:       side_in.flag   = !a_gt_b;
         fpa_pkg::ACT_EQ:       side_in.flag   = (in_a_ff == in_b_ff);
         fpa_pkg::ACT_NE:       side_in.flag   = (in_a_ff != in_b_ff);
         fpa_pkg::ACT_MAX:      side_in.result = a_gt_b ? in_a_ff : in_b_ff;
         fpa_pkg::ACT_MIN:      side_in.result = b_gt_a ? in_a_ff : in_b_ff;
         fpa_pkg::ACT_INC:      side_in.result = WORD_BITS'(in_a_ff + 1'b1);
         fpa_pkg::ACT_FROM_INT: side_in.result = in_a_ff << FRAC_BITS;
         fpa_pkg::ACT_TO_INT:   side_in.result = in_a_ff >>> FRAC_BITS;
         default:               side_in.result = '0;
      endcase
   end

   // delay line matched to the divider depth
   for (genvar k = 0; k < N; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else if (advance) begin
            side_ff[k].valid <= (k == 0) ? side_in.valid : side_ff[(k == 0) ? 0 : k-1].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (k == 0) begin
               side_ff[k].is_div   <= side_in.is_div;
               side_ff[k].negate   <= side_in.negate;
               side_ff[k].zero_div <= side_in.zero_div;
               side_ff[k].result   <= side_in.result;
               side_ff[k].flag     <= side_in.flag;
            end else begin
               side_ff[k].is_div   <= side_ff[(k == 0) ? 0 : k-1].is_div;
               side_ff[k].negate   <= side_ff[(k == 0) ? 0 : k-1].negate;
               side_ff[k].zero_div <= side_ff[(k == 0) ? 0 : k-1].zero_div;
               side_ff[k].result   <= side_ff[(k == 0) ? 0 : k-1].result;
               side_ff[k].flag     <= side_ff[(k == 0) ? 0 : k-1].flag;
            end
         end
      end
   end

   fpa_div #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (mag_a),
      .divisor  (mag_b),
      .quotient (quotient)
   );

   // apply the quotient sign, drop a divide by zero to 0
   assign quo_word = quotient[WORD_BITS-1:0];

   always_comb begin
      if (side_ff[N-1].is_div) begin
         if (side_ff[N-1].zero_div) begin
            final_result = '0;
         end else if (side_ff[N-1].negate) begin
            final_result = WORD_BITS'(-quo_word);
         end else begin
            final_result = quo_word;
         end
      end else begin
         final_result = side_ff[N-1].result;
      end
   end

   // output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= side_ff[N-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= final_result;
         rsp_flag_ff   <= side_ff[N-1].flag;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_flag   = rsp_flag_ff;

endmodule

// ===== rtl/fpa_checker.sv =====
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks for the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker #(
   parameter int unsigned WORD_BITS = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WORD_BITS-1:0] rsp_result,
   input logic                 rsp_flag
);

   // a held result word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result) && $stable(rsp_flag))
      else $error("result word changed while stalled");

   // input stalls only behind a stalled output word
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with no blocked output");

   // comparisons carry a zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flag |-> rsp_result == '0)
      else $error("flag set with nonzero result");

   // no word comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fixed_point_alu_q24_8 fpa_checker #(.WORD_BITS(WORD_BITS)) u_fpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_result (rsp_result),
   .rsp_flag   (rsp_flag)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q24.8 fixed-point ALU. Feeds directed corner
// words and random words through a valid/stall driver, predicts each result
// in order and compares result and flag on every accepted output word.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      logic [3:0]         action;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } alu_word_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               flag;
   } alu_result_type;

   localparam int LATENCY   = 42;
   localparam int WDOG_MAX  = 5000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_action;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_result;
   logic               rsp_flag;

   alu_word_type   pending_q[$];
   alu_result_type expected_q[$];
   int             error_count;
   int             idle_cycles;
   bit             stim_done;
   bit             quiet_phase;
   bit             holdoff_req;
   int             holdoff_left;

   fixed_point_alu_q24_8 uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result(rsp_result), .rsp_flag(rsp_flag)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Predict one ALU result from an accepted word.
   function automatic alu_result_type alu_predict(alu_word_type w);
      logic signed [63:0]  a;
      logic signed [63:0]  b;
      logic signed [63:0]  prod;
      logic signed [127:0] num;
      logic signed [127:0] quot;
      alu_result_type      r;
      a = w.operand_a;
      b = w.operand_b;
      r.result = '0;
      r.flag   = 1'b0;
      case (fpa_pkg::action_type'(w.action))
         fpa_pkg::ACT_ADD:      r.result = w.operand_a + w.operand_b;
         fpa_pkg::ACT_SUB:      r.result = w.operand_a - w.operand_b;
         fpa_pkg::ACT_MUL: begin
            prod = a * b;
            r.result = 32'(prod >>> 8);
         end
         fpa_pkg::ACT_DIV: begin
            if (b != 0) begin
               num  = 128'(a) <<< 8;
               quot = num / 128'(b);   // signed divide truncates toward zero
               r.result = quot[31:0];
            end
         end
         fpa_pkg::ACT_GT:       r.flag = a > b;
         fpa_pkg::ACT_LT:       r.flag = a < b;
         fpa_pkg::ACT_GE:       r.flag = a >= b;
         fpa_pkg::ACT_LE:       r.flag = a <= b;
         fpa_pkg::ACT_EQ:       r.flag = a == b;
         fpa_pkg::ACT_NE:       r.flag = a != b;
         fpa_pkg::ACT_MAX:      r.result = (a > b) ? w.operand_a : w.operand_b;
         fpa_pkg::ACT_MIN:      r.result = (a < b) ? w.operand_a : w.operand_b;
         fpa_pkg::ACT_INC:      r.result = w.operand_a + 32'sd1;
         fpa_pkg::ACT_FROM_INT: r.result = w.operand_a <<< 8;
         fpa_pkg::ACT_TO_INT:   r.result = w.operand_a >>> 8;
         default:      ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   task automatic queue_word(fpa_pkg::action_type act, logic [31:0] a, logic [31:0] b);
      alu_word_type w;
      w.action    = act;
      w.operand_a = a;
      w.operand_b = b;
      pending_q.push_back(w);
   endtask

   function automatic logic [31:0] rand_operand();
      // Mix small values, corners and full-range words.
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         1: return 32'($signed($urandom_range(0, 2048)) - 1024);
         2: return {{16{1'b0}}, 16'($urandom)};
         3: return 32'($urandom) >>> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Directed corners, then random words.
   initial begin
      logic [31:0] corners[6];
      corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
      // every action, including the unused code, with extreme operands
      for (int i = 0; i < 16; i++)
         queue_word(fpa_pkg::action_type'(i), corners[i % 6], corners[(i + 3) % 6]);
      // divide by zero, quotient overflow, equal operands for max/min, and mul, to-int and inc corners
      queue_word(fpa_pkg::ACT_DIV, 32'h0000_1234, 32'h0);
      queue_word(fpa_pkg::ACT_DIV, 32'h7fff_ffff, 32'h1);
      queue_word(fpa_pkg::ACT_DIV, 32'h8000_0000, 32'hffff_ffff);
      queue_word(fpa_pkg::ACT_MAX, 32'h0000_0500, 32'h0000_0500);
      queue_word(fpa_pkg::ACT_MIN, 32'hffff_fb00, 32'hffff_fb00);
      queue_word(fpa_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000);
      queue_word(fpa_pkg::ACT_TO_INT, 32'hffff_ff01, 32'h0);
      queue_word(fpa_pkg::ACT_INC, 32'h7fff_ffff, 32'hffff_ffff);
      for (int i = 0; i < 500; i++)
         queue_word(fpa_pkg::action_type'($urandom_range(0, 15)), rand_operand(),
                    rand_operand());
   end

   // Reset, then track quiet stretch (no idling) and one long receiver hold-off.
   initial begin
      reset = 1'b1;
      quiet_phase = 1'b0;
      holdoff_req = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (150) @(posedge clock);
      quiet_phase = 1'b1;
      repeat (120) @(posedge clock);
      quiet_phase = 1'b0;
      holdoff_req = 1'b1;
   end

   // Driver: hold the word while stalled, advance on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_action    <= '0;
         req_operand_a <= '0;
         req_operand_b <= '0;
      end else if (!req_valid || !req_stall) begin
         if (pending_q.size() != 0 && (quiet_phase || $urandom_range(0, 99) >= 30)) begin
            alu_word_type w;
            w = pending_q.pop_front();
            req_valid     <= 1'b1;
            req_action    <= w.action;
            req_operand_a <= w.operand_a;
            req_operand_b <= w.operand_b;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict at acceptance so expectations stay in issue order.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_q.push_back(alu_predict({req_action, req_operand_a, req_operand_b}));
   end

   // Receiver stall: random, off during the quiet stretch, one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         holdoff_left <= 0;
      end else if (holdoff_req && holdoff_left == 0 && !stim_done) begin
         holdoff_left <= 200;
         rsp_stall    <= 1'b1;
      end else if (holdoff_left > 1) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall    <= 1'b1;
      end else begin
         if (holdoff_left == 1) begin
            holdoff_left <= -1;   // hold-off done, never again
         end
         rsp_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 30);
      end
   end

   // Monitor: compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_result, 32'h0);
         end else begin
            alu_result_type e;
            e = expected_q.pop_front();
            if (rsp_result !== e.result) report_mismatch("result", rsp_result, e.result);
            if (rsp_flag !== e.flag)
               report_mismatch("flag", {31'b0, rsp_flag}, {31'b0, e.flag});
         end
      end
   end

   // Watchdog: count cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      error_count = 0;
      stim_done   = 1'b0;
      idle_cycles = 0;
      @(negedge reset);
      fork
         begin
            wait (pending_q.size() == 0 && !(req_valid && req_stall));
            @(posedge clock);
            stim_done = 1'b1;
            wait (expected_q.size() == 0);
            repeat (2 * LATENCY) @(posedge clock);
            if (expected_q.size() != 0)
               error_count++;
            if (error_count == 0)
               $display("Testbench completed without errors");
            else
               $display("Testbench completed WITH ERRORS");
         end
         begin
            wait (idle_cycles >= WDOG_MAX);
            $display("Testbench completed WITH ERRORS");
         end
      join_any
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fpa_pkg.sv
rtl/fpa_div.sv
rtl/fixed_point_alu_q24_8.sv
rtl/fpa_checker.sv
test/tb.sv
